[rtl/bpce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpce_pkg;

  // Request actions.
  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_OPEN  = 3'd1;
  localparam logic [2:0] ACT_CLOSE = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // Result status codes.
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_EOF      = 3'd1;
  localparam logic [2:0] STS_BLOCK    = 3'd2;
  localparam logic [2:0] STS_BROKEN   = 3'd3;
  localparam logic [2:0] STS_BAD      = 3'd4;
  localparam logic [2:0] STS_NOPIPE   = 3'd5;
  localparam logic [2:0] STS_NOHANDLE = 3'd6;

  // End kinds.
  localparam logic END_READ  = 1'b0;
  localparam logic END_WRITE = 1'b1;

  // Per-pipe end counters saturate at this value.
  localparam int unsigned END_W = 5;
  localparam logic [END_W-1:0] END_MAX = 5'd31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take the request and start the pipe record lookup
    logic commit;      // execute the request and write back its state
    logic fetch_load;  // place the fetched byte into the result
  } bpce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_fetch; // the request reads a byte from the ring store
  } bpce_sts_t;

endpackage

`default_nettype wire

[rtl/bpce_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  bpce_pkg::bpce_sts_t sts_i,
  output bpce_pkg::bpce_cmd_t cmd_o
);
  import bpce_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_FETCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   load;

  // The result register may be refilled when it is empty or is being taken now.
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o        = (state_q != S_IDLE);
  assign cmd_o.capture     = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit      = (state_q == S_EXEC) && out_free;
  assign cmd_o.fetch_load  = (state_q == S_FETCH);
  assign load = (cmd_o.commit && !sts_i.needs_fetch) || cmd_o.fetch_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = sts_i.needs_fetch ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_fetch_follows_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> $past(cmd_o.commit) && $past(sts_i.needs_fetch))
    else $error("byte fetch entered without a committed read");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FETCH))
    else $error("result raised outside execute or fetch");

  a_hold_on_blocked_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && out_valid_q && out_stall_i |=> state_q == S_EXEC)
    else $error("execute left while the previous result was still stalled");
`endif

endmodule

`default_nettype wire

[rtl/bpce_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpce_dpath #(
  parameter int unsigned PIPE_COUNT = 8,
  parameter int unsigned BUF_DEPTH  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpce_pkg::bpce_cmd_t cmd_i,
  output bpce_pkg::bpce_sts_t sts_o,
  input  logic [2:0]          action_i,
  input  logic [2:0]          pipe_sel_i,
  input  logic                end_kind_i,
  input  logic [7:0]          data_in_i,
  input  logic                last_of_call_i,
  input  logic [7:0]          task_id_i,
  output logic [2:0]          status_o,
  output logic [2:0]          pipe_out_o,
  output logic [7:0]          data_out_o,
  output logic                wake_reader_o,
  output logic [7:0]          reader_task_o,
  output logic                wake_writer_o,
  output logic [7:0]          writer_task_o
);
  import bpce_pkg::*;

  localparam int unsigned PIDX_W  = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int unsigned BIDX_W  = $clog2(BUF_DEPTH);
  localparam int unsigned FILL_W  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned HND_MAX = 2 * PIPE_COUNT;
  localparam int unsigned HND_W   = $clog2(HND_MAX + 1);
  localparam int unsigned ADDR_W  = PIDX_W + BIDX_W;

  typedef struct packed {
    logic [BIDX_W-1:0] head;
    logic [BIDX_W-1:0] tail;
    logic [FILL_W-1:0] fill;
    logic [END_W-1:0]  readers;
    logic [END_W-1:0]  writers;
    logic              rwv;
    logic [7:0]        rwt;
    logic              wwv;
    logic [7:0]        wwt;
  } pipe_rec_t;

  // Request registers.
  logic [2:0] act_q;
  logic [2:0] sel_q;
  logic       endk_q;
  logic [7:0] data_q;
  logic       last_q;
  logic [7:0] task_q;

  // Pipe records; a record without its valid bit reads as all zero.
  pipe_rec_t             rec_mem [PIPE_COUNT];
  logic [PIPE_COUNT-1:0] rec_vld_q;
  logic [PIPE_COUNT-1:0] busy_q;
  pipe_rec_t             rec_rd_q;
  logic                  rd_vld_q;
  logic [HND_W-1:0]      hnd_q, hnd_d;

  logic [7:0] byte_mem [2**ADDR_W];
  logic [7:0] byte_rd_q;

  logic [PIDX_W-1:0] idx_in, idx_q, alloc_idx;
  logic              in_rng_in, in_rng;
  logic              alloc_hit;
  pipe_rec_t         rec, rec_nxt;
  logic              wr_rec, rec_we, clr_vld;
  logic              bwe, bre;
  logic [END_W-1:0]  cnt;
  logic [2:0]        status_d, pout_d;
  logic              wr_d, ww_d;
  logic [7:0]        rtask_d, wtask_d;

  logic [2:0] status_q, pout_q;
  logic [7:0] dout_q, rtask_q, wtask_q;
  logic       wr_q, ww_q;

  assign idx_in    = PIDX_W'(pipe_sel_i);
  assign idx_q     = PIDX_W'(sel_q);
  assign in_rng_in = (32'(pipe_sel_i) < PIPE_COUNT);
  assign in_rng    = (32'(sel_q) < PIPE_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_i;
      sel_q    <= pipe_sel_i;
      endk_q   <= end_kind_i;
      data_q   <= data_in_i;
      last_q   <= last_of_call_i;
      task_q   <= task_id_i;
      rec_rd_q <= rec_mem[idx_in];
      rd_vld_q <= in_rng_in && rec_vld_q[idx_in];
    end
    if (rec_we) begin
      rec_mem[idx_q] <= rec_nxt;
    end
  end

  // Lowest-numbered pipe with no open ends.
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        alloc_hit = 1'b1;
        alloc_idx = PIDX_W'(i);
      end
    end
  end

  assign rec = rd_vld_q ? rec_rd_q : '0;
  assign cnt = endk_q ? rec.writers : rec.readers;

  always_comb begin
    rec_nxt  = rec;
    wr_rec   = 1'b0;
    clr_vld  = 1'b0;
    bwe      = 1'b0;
    bre      = 1'b0;
    hnd_d    = hnd_q;
    status_d = STS_BAD;
    pout_d   = sel_q;
    wr_d     = 1'b0;
    rtask_d  = '0;
    ww_d     = 1'b0;
    wtask_d  = '0;

    if (act_q == ACT_ALLOC) begin
      status_d = STS_NOPIPE;
      if (alloc_hit) begin
        clr_vld  = 1'b1;
        status_d = STS_OK;
        pout_d   = 3'(alloc_idx);
      end
    end else if (in_rng) begin
      case (act_q)
        ACT_OPEN: begin
          if (hnd_q >= HND_W'(HND_MAX) || cnt == END_MAX) begin
            status_d = STS_NOHANDLE;
          end else begin
            if (endk_q == END_WRITE) begin
              rec_nxt.writers = rec.writers + 1'b1;
            end else begin
              rec_nxt.readers = rec.readers + 1'b1;
            end
            hnd_d    = hnd_q + 1'b1;
            wr_rec   = 1'b1;
            status_d = STS_OK;
          end
        end
        ACT_CLOSE: begin
          if (endk_q == END_WRITE) begin
            rec_nxt.writers = (rec.writers != '0) ? rec.writers - 1'b1 : rec.writers;
            if (rec_nxt.writers == '0 && rec.rwv) begin
              wr_d        = 1'b1;
              rtask_d     = rec.rwt;
              rec_nxt.rwv = 1'b0;
            end
          end else begin
            rec_nxt.readers = (rec.readers != '0) ? rec.readers - 1'b1 : rec.readers;
            if (rec_nxt.readers == '0 && rec.wwv) begin
              ww_d        = 1'b1;
              wtask_d     = rec.wwt;
              rec_nxt.wwv = 1'b0;
            end
          end
          hnd_d    = (hnd_q != '0) ? hnd_q - 1'b1 : hnd_q;
          wr_rec   = 1'b1;
          status_d = STS_OK;
        end
        ACT_WRITE: begin
          if (endk_q != END_WRITE || rec.writers == '0) begin
            status_d = STS_BAD;
          end else if (rec.readers == '0) begin
            status_d = STS_BROKEN;
          end else if (rec.fill == FILL_W'(BUF_DEPTH)) begin
            status_d    = STS_BLOCK;
            rec_nxt.wwv = 1'b1;
            rec_nxt.wwt = task_q;
            wr_rec      = 1'b1;
          end else begin
            bwe          = 1'b1;
            rec_nxt.tail = (rec.tail == BIDX_W'(BUF_DEPTH - 1)) ? '0 : rec.tail + 1'b1;
            rec_nxt.fill = rec.fill + 1'b1;
            wr_rec       = 1'b1;
            status_d     = STS_OK;
            if (last_q && rec.rwv) begin
              wr_d        = 1'b1;
              rtask_d     = rec.rwt;
              rec_nxt.rwv = 1'b0;
            end
          end
        end
        ACT_READ: begin
          if (endk_q != END_READ || rec.readers == '0) begin
            status_d = STS_BAD;
          end else if (rec.fill == '0) begin
            if (rec.writers == '0) begin
              status_d = STS_EOF;
            end else begin
              status_d    = STS_BLOCK;
              rec_nxt.rwv = 1'b1;
              rec_nxt.rwt = task_q;
              wr_rec      = 1'b1;
            end
          end else begin
            bre          = 1'b1;
            rec_nxt.head = (rec.head == BIDX_W'(BUF_DEPTH - 1)) ? '0 : rec.head + 1'b1;
            rec_nxt.fill = rec.fill - 1'b1;
            wr_rec       = 1'b1;
            status_d     = STS_OK;
            if (last_q && rec.wwv) begin
              ww_d        = 1'b1;
              wtask_d     = rec.wwt;
              rec_nxt.wwv = 1'b0;
            end
          end
        end
        default: begin
          status_d = STS_BAD;
        end
      endcase
    end
  end

  assign rec_we            = cmd_i.commit && wr_rec;
  assign sts_o.needs_fetch = bre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= '0;
      busy_q    <= '0;
      hnd_q     <= '0;
    end else if (cmd_i.commit) begin
      if (wr_rec) begin
        rec_vld_q[idx_q] <= 1'b1;
        busy_q[idx_q]    <= (rec_nxt.readers != '0) || (rec_nxt.writers != '0);
      end
      if (clr_vld) begin
        rec_vld_q[alloc_idx] <= 1'b0;
      end
      hnd_q <= hnd_d;
    end
  end

  // Ring byte store, addressed by pipe and ring position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && bwe) begin
      byte_mem[{idx_q, rec.tail}] <= data_q;
    end
    if (cmd_i.commit && bre) begin
      byte_rd_q <= byte_mem[{idx_q, rec.head}];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      pout_q   <= pout_d;
      dout_q   <= '0;
      wr_q     <= wr_d;
      rtask_q  <= rtask_d;
      ww_q     <= ww_d;
      wtask_q  <= wtask_d;
    end else if (cmd_i.fetch_load) begin
      dout_q <= byte_rd_q;
    end
  end

  assign status_o      = status_q;
  assign pipe_out_o    = pout_q;
  assign data_out_o    = dout_q;
  assign wake_reader_o = wr_q;
  assign reader_task_o = rtask_q;
  assign wake_writer_o = ww_q;
  assign writer_task_o = wtask_q;

`ifndef SYNTHESIS
  a_handles_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hnd_q <= HND_W'(HND_MAX))
    else $error("open handle count beyond the pool limit");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_we |-> rec_nxt.fill <= FILL_W'(BUF_DEPTH))
    else $error("pipe fill count beyond the ring depth");
`endif

endmodule

`default_nettype wire

[rtl/byte_pipe_channel_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte pipe channel engine: a pool of PIPE_COUNT byte pipes, each a ring of
// BUF_DEPTH bytes with counts of open read and write ends, plus a global count
// of open handles. Every request (allocate, open, close, write byte, read byte)
// yields exactly one result carrying a status, the pipe id, a read byte and any
// waiter to be woken. A request that would have to wait returns would_block and
// its task id is kept as the pipe's waiter until the peer makes progress on the
// last byte of a call or closes its last end. For each request the pipe record is
// read from its memory, then the request executes and writes the record back;
// a read that returns a byte then passes through a fetch state for the ring
// store read. Only one request is in flight at a time, so the next request is
// taken once the previous one has reached the result register, which may still
// be waiting to be taken. No clearing pass follows reset: pipe records carry
// valid bits and the ring store is only ever read where it has been written.
module byte_pipe_channel_engine_unit #(
  parameter int unsigned PIPE_COUNT = 8,
  parameter int unsigned BUF_DEPTH  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [2:0] pipe_sel_i,
  input  logic       end_kind_i,
  input  logic [7:0] data_in_i,
  input  logic       last_of_call_i,
  input  logic [7:0] task_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [2:0] pipe_out_o,
  output logic [7:0] data_out_o,
  output logic       wake_reader_o,
  output logic [7:0] reader_task_o,
  output logic       wake_writer_o,
  output logic [7:0] writer_task_o
);
  import bpce_pkg::*;

  // The controller sequences each request; the datapath holds all pipe state.
  bpce_cmd_t cmd;
  bpce_sts_t sts;

  bpce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpce_dpath #(
    .PIPE_COUNT (PIPE_COUNT),
    .BUF_DEPTH  (BUF_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .pipe_sel_i     (pipe_sel_i),
    .end_kind_i     (end_kind_i),
    .data_in_i      (data_in_i),
    .last_of_call_i (last_of_call_i),
    .task_id_i      (task_id_i),
    .status_o       (status_o),
    .pipe_out_o     (pipe_out_o),
    .data_out_o     (data_out_o),
    .wake_reader_o  (wake_reader_o),
    .reader_task_o  (reader_task_o),
    .wake_writer_o  (wake_writer_o),
    .writer_task_o  (writer_task_o)
  );

endmodule

`default_nettype wire

[tb/tb_pipe_pool_pkg.sv]
`timescale 1ns / 1ps

package tb_pipe_pool_pkg;

  import bpce_pkg::*;

  localparam int unsigned NUM_PIPES  = 8;
  localparam int unsigned RING_DEPTH = 256;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] pipe_sel;
    logic       end_kind;
    logic [7:0] data;
    logic       last;
    logic [7:0] task_id;
  } pipe_req_t;

  // Field order matches the concatenation of the result ports in the monitor.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] pipe;
    logic [7:0] data;
    logic       wake_rd;
    logic [7:0] rd_task;
    logic       wake_wr;
    logic [7:0] wr_task;
  } pipe_res_t;

  // Tracks the pipe pool as the block should see it and keeps the results
  // that accepted requests are owed, oldest first.
  class pipe_pool_tracker;
    logic [7:0]  ring_mem [NUM_PIPES*RING_DEPTH];
    logic [7:0]  head [NUM_PIPES];
    logic [7:0]  tail [NUM_PIPES];
    logic [8:0]  level [NUM_PIPES];
    logic [4:0]  readers [NUM_PIPES];
    logic [4:0]  writers [NUM_PIPES];
    bit          rd_wait [NUM_PIPES];
    logic [7:0]  rd_wait_task [NUM_PIPES];
    bit          wr_wait [NUM_PIPES];
    logic [7:0]  wr_wait_task [NUM_PIPES];
    logic [4:0]  handles;
    pipe_res_t   pending_results[$];
    pipe_res_t   last_expect;
    int unsigned requests;
    int unsigned checked;
    int unsigned errors;
    int unsigned status_seen [8];

    function new();
      for (int unsigned i = 0; i < NUM_PIPES; i++) begin
        clear_pipe(i);
        readers[i] = '0;
        writers[i] = '0;
      end
      for (int unsigned i = 0; i < 8; i++) status_seen[i] = 0;
      handles  = '0;
      requests = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    function void clear_pipe(int unsigned i);
      head[i]         = '0;
      tail[i]         = '0;
      level[i]        = '0;
      rd_wait[i]      = 1'b0;
      rd_wait_task[i] = '0;
      wr_wait[i]      = 1'b0;
      wr_wait_task[i] = '0;
    endfunction

    function void note_request(pipe_req_t r);
      pipe_res_t   e;
      int unsigned p;
      bit          found;
      e        = '0;
      e.status = STS_BAD;
      e.pipe   = r.pipe_sel;
      p        = r.pipe_sel;
      found    = 1'b0;
      requests++;
      if (r.action == ACT_ALLOC) begin
        e.status = STS_NOPIPE;
        for (int unsigned i = 0; i < NUM_PIPES; i++) begin
          if (!found && readers[i] == 0 && writers[i] == 0) begin
            found = 1'b1;
            clear_pipe(i);
            e.status = STS_OK;
            e.pipe   = 3'(i);
          end
        end
      end else if (r.action <= ACT_READ && p < NUM_PIPES) begin
        case (r.action)
          ACT_OPEN: begin
            if (handles >= 2*NUM_PIPES ||
                (r.end_kind == END_WRITE ? writers[p] : readers[p]) >= END_MAX) begin
              e.status = STS_NOHANDLE;
            end else begin
              if (r.end_kind == END_WRITE) writers[p]++;
              else readers[p]++;
              handles++;
              e.status = STS_OK;
            end
          end
          ACT_CLOSE: begin
            // The last writer leaving releases a parked reader, and the last
            // reader leaving releases a parked writer.
            if (r.end_kind == END_WRITE) begin
              if (writers[p] > 0) writers[p]--;
              if (writers[p] == 0 && rd_wait[p]) begin
                e.wake_rd  = 1'b1;
                e.rd_task  = rd_wait_task[p];
                rd_wait[p] = 1'b0;
              end
            end else begin
              if (readers[p] > 0) readers[p]--;
              if (readers[p] == 0 && wr_wait[p]) begin
                e.wake_wr  = 1'b1;
                e.wr_task  = wr_wait_task[p];
                wr_wait[p] = 1'b0;
              end
            end
            if (handles > 0) handles--;
            e.status = STS_OK;
          end
          ACT_WRITE: begin
            if (r.end_kind != END_WRITE || writers[p] == 0) begin
              e.status = STS_BAD;
            end else if (readers[p] == 0) begin
              e.status = STS_BROKEN;
            end else if (level[p] >= RING_DEPTH) begin
              e.status        = STS_BLOCK;
              wr_wait[p]      = 1'b1;
              wr_wait_task[p] = r.task_id;
            end else begin
              ring_mem[p*RING_DEPTH + tail[p]] = r.data;
              tail[p]  = 8'((tail[p] + 1) % RING_DEPTH);
              level[p] = level[p] + 1;
              e.status = STS_OK;
              if (r.last && rd_wait[p]) begin
                e.wake_rd  = 1'b1;
                e.rd_task  = rd_wait_task[p];
                rd_wait[p] = 1'b0;
              end
            end
          end
          default: begin
            if (r.end_kind != END_READ || readers[p] == 0) begin
              e.status = STS_BAD;
            end else if (level[p] == 0) begin
              if (writers[p] == 0) begin
                e.status = STS_EOF;
              end else begin
                e.status        = STS_BLOCK;
                rd_wait[p]      = 1'b1;
                rd_wait_task[p] = r.task_id;
              end
            end else begin
              e.data   = ring_mem[p*RING_DEPTH + head[p]];
              head[p]  = 8'((head[p] + 1) % RING_DEPTH);
              level[p] = level[p] - 1;
              e.status = STS_OK;
              if (r.last && wr_wait[p]) begin
                e.wake_wr  = 1'b1;
                e.wr_task  = wr_wait_task[p];
                wr_wait[p] = 1'b0;
              end
            end
          end
        endcase
      end
      last_expect = e;
      pending_results.push_back(e);
    endfunction

    // Four-state compare, so that an unknown on a result port is a mismatch.
    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pipe_res_t got);
      pipe_res_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding (status %0d, pipe_out %0d)",
               got.status, got.pipe);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      status_seen[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("pipe_out", want.pipe, got.pipe);
      compare_field("data_out", want.data, got.data);
      compare_field("wake_reader", want.wake_rd, got.wake_rd);
      compare_field("reader_task", want.rd_task, got.rd_task);
      compare_field("wake_writer", want.wake_wr, got.wake_wr);
      compare_field("writer_task", want.wr_task, got.wr_task);
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Top level of the pipe pool testbench. Requests are driven one at a time with
// random gaps, the result side stalls at random, and every accepted result is
// checked field by field against the tracker in tb_pipe_pool_pkg.
module tb_top;

  import bpce_pkg::*;
  import tb_pipe_pool_pkg::*;

  // The random part stops issuing new sessions once this many requests have
  // been accepted; it is not checked against anything at the end.
  localparam int unsigned REQUEST_TARGET = 1050;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] action;
  logic [2:0] pipe_sel;
  logic       end_kind;
  logic [7:0] data_in;
  logic       last_of_call;
  logic [7:0] task_id;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  logic [2:0] pipe_out;
  logic [7:0] data_out;
  logic       wake_rd;
  logic [7:0] rd_task;
  logic       wake_wr;
  logic [7:0] wr_task;

  // When set, the sender or the receiver runs flat out with no idle cycles.
  bit send_no_gaps = 1'b0;
  bit sink_no_stall = 1'b0;

  pipe_pool_tracker sb;

  always #5 clk = ~clk;

  byte_pipe_channel_engine_unit #(
    .PIPE_COUNT(NUM_PIPES),
    .BUF_DEPTH (RING_DEPTH)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .pipe_sel_i    (pipe_sel),
    .end_kind_i    (end_kind),
    .data_in_i     (data_in),
    .last_of_call_i(last_of_call),
    .task_id_i     (task_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .pipe_out_o    (pipe_out),
    .data_out_o    (data_out),
    .wake_reader_o (wake_rd),
    .reader_task_o (rd_task),
    .wake_writer_o (wake_wr),
    .writer_task_o (wr_task)
  );

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Roughly one byte in three closes its call.
  function automatic logic rand_last();
    return ($urandom_range(0, 2) == 0);
  endfunction

  // Drives one request after a random gap and holds it until the block takes
  // it. The valid line is only ever assigned once per clock edge: it is either
  // lowered for a gap or kept high straight into the next request.
  task automatic issue(input logic [2:0] act, input logic [2:0] sel,
                       input logic end_k, input logic [7:0] data,
                       input logic last, input logic [7:0] tid);
    pipe_req_t   req;
    int unsigned gap;
    req = {act, sel, end_k, data, last, tid};
    if ($urandom_range(0, 47) == 0) send_no_gaps = !send_no_gaps;
    gap = send_no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    pipe_sel     <= sel;
    end_kind     <= end_k;
    data_in      <= data;
    last_of_call <= last;
    task_id      <= tid;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic put_byte(input logic [2:0] p, input logic last);
    issue(ACT_WRITE, p, END_WRITE, rnd8(), last, rnd8());
  endtask

  task automatic get_byte(input logic [2:0] p, input logic last);
    issue(ACT_READ, p, END_READ, rnd8(), last, rnd8());
  endtask

  task automatic pipe_open(input logic [2:0] p, input logic end_k);
    issue(ACT_OPEN, p, end_k, rnd8(), rand_last(), rnd8());
  endtask

  task automatic pipe_close(input logic [2:0] p, input logic end_k);
    issue(ACT_CLOSE, p, end_k, rnd8(), rand_last(), rnd8());
  endtask

  // Closes every end still open, so that the whole pool is free again. The
  // tracker is up to date here because each request is noted on acceptance.
  task automatic close_all();
    for (int unsigned i = 0; i < NUM_PIPES; i++) begin
      while (sb.readers[i] > 0) pipe_close(3'(i), END_READ);
      while (sb.writers[i] > 0) pipe_close(3'(i), END_WRITE);
    end
  endtask

  // Allocates a pipe, freeing the pool first if every pipe is taken.
  task automatic claim_pipe(output logic [2:0] p);
    issue(ACT_ALLOC, 3'($urandom), 1'($urandom), rnd8(), rand_last(), rnd8());
    if (sb.last_expect.status != STS_OK) begin
      close_all();
      issue(ACT_ALLOC, 3'($urandom), 1'($urandom), rnd8(), rand_last(), rnd8());
    end
    p = sb.last_expect.pipe;
  endtask

  // Fills one pipe to the brim and drains it again, so that both ring indices
  // wrap. On the way it parks writers on the full pipe, releases one by a
  // read and one by the last reader leaving, and finishes with end of file.
  task automatic fill_session();
    logic [2:0] p;
    close_all();
    claim_pipe(p);
    pipe_open(p, END_READ);
    pipe_open(p, END_WRITE);
    repeat (RING_DEPTH) put_byte(p, rand_last());
    // Two writers find it full; the second replaces the first as the waiter.
    put_byte(p, 1'b1);
    put_byte(p, 1'b1);
    get_byte(p, 1'b1);
    put_byte(p, rand_last());
    put_byte(p, 1'b0);
    pipe_close(p, END_READ);
    put_byte(p, 1'b1);
    pipe_open(p, END_READ);
    repeat (RING_DEPTH) get_byte(p, rand_last());
    get_byte(p, 1'b0);
    put_byte(p, 1'b1);
    get_byte(p, 1'b0);
    get_byte(p, 1'b0);
    pipe_close(p, END_WRITE);
    get_byte(p, rand_last());
    close_all();
  endtask

  // A short conversation on one pipe with a random mix of writes and reads,
  // ending in one of several ways: writers leave first and the reader runs
  // into end of file, readers leave first and the writer gets a broken pipe,
  // or the ends are left open for a later session to reclaim.
  task automatic stream_session();
    logic [2:0]  p;
    int unsigned n_rd;
    int unsigned n_wr;
    int unsigned ops;
    int unsigned wbias;
    if (sb.handles > 2*NUM_PIPES - 4) close_all();
    claim_pipe(p);
    n_rd = $urandom_range(1, 2);
    n_wr = $urandom_range(1, 2);
    repeat (n_rd) pipe_open(p, END_READ);
    repeat (n_wr) pipe_open(p, END_WRITE);
    ops   = $urandom_range(4, 30);
    wbias = $urandom_range(1, 3);
    repeat (ops) begin
      if ($urandom_range(0, 3) < wbias) put_byte(p, rand_last());
      else get_byte(p, rand_last());
    end
    case ($urandom_range(0, 3))
      0: begin
        // Park a reader on an empty pipe so that the last writer wakes it.
        if (sb.level[p] == 0) get_byte(p, 1'b0);
        repeat (n_wr) pipe_close(p, END_WRITE);
        repeat (sb.level[p] + 1) get_byte(p, rand_last());
      end
      1: begin
        repeat (n_rd) pipe_close(p, END_READ);
        put_byte(p, rand_last());
      end
      default: begin
      end
    endcase
  endtask

  // Opens more ends than the handle table holds, then closes a few at random,
  // some of them on ends that are already shut.
  task automatic handle_flood();
    close_all();
    repeat (2*NUM_PIPES + $urandom_range(1, 3)) pipe_open(3'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 4)) pipe_close(3'($urandom), 1'($urandom));
    close_all();
  endtask

  // Takes every pipe in the pool, asks for two more, then frees a single pipe
  // and checks that allocation finds exactly that one.
  task automatic pool_flood();
    logic [2:0] victim;
    close_all();
    repeat (NUM_PIPES) begin
      issue(ACT_ALLOC, 3'($urandom), 1'($urandom), rnd8(), rand_last(), rnd8());
      pipe_open(sb.last_expect.pipe, 1'($urandom));
    end
    repeat (2) issue(ACT_ALLOC, 3'($urandom), 1'($urandom), rnd8(), rand_last(), rnd8());
    victim = 3'($urandom);
    while (sb.readers[victim] > 0) pipe_close(victim, END_READ);
    while (sb.writers[victim] > 0) pipe_close(victim, END_WRITE);
    issue(ACT_ALLOC, 3'($urandom), 1'($urandom), rnd8(), rand_last(), rnd8());
    close_all();
  endtask

  // Fully random requests, unknown actions included.
  task automatic noise_burst();
    repeat ($urandom_range(4, 16)) begin
      issue(3'($urandom), 3'($urandom), 1'($urandom), rnd8(), 1'($urandom), rnd8());
    end
  endtask

  // Result side: stalls for a random number of cycles before each result,
  // with occasional stretches where it never stalls at all.
  initial begin : result_sink
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_no_stall = !sink_no_stall;
      hold = sink_no_stall ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Sampling at the edge sees the values from before any update made at that
  // edge, so the order of processes within the time step does not matter.
  always @(posedge clk) begin : result_monitor
    pipe_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {status, pipe_out, data_out, wake_rd, rd_task, wake_wr, wr_task};
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    action       <= ACT_ALLOC;
    pipe_sel     <= '0;
    end_kind     <= END_READ;
    data_in      <= '0;
    last_of_call <= 1'b0;
    task_id      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Reads and writes with no end open are refused, a
    // close with nothing open only saturates, and allocate ignores pipe_sel.
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b1, 8'h00);
    issue(ACT_WRITE, 3'd7, END_WRITE, 8'hFF, 1'b1, 8'hFF);
    issue(ACT_CLOSE, 3'd7, END_WRITE, 8'h00, 1'b0, 8'h00);
    issue(ACT_ALLOC, 3'd7, END_WRITE, 8'hFF, 1'b1, 8'hFF);
    issue(ACT_OPEN, 3'd0, END_READ, 8'h00, 1'b0, 8'h00);
    issue(ACT_OPEN, 3'd0, END_WRITE, 8'h00, 1'b0, 8'h00);
    // Two readers park on the empty pipe; the later one is kept and is woken
    // only by the write that ends the writer's call.
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b0, 8'hA5);
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b0, 8'h5A);
    issue(ACT_WRITE, 3'd0, END_WRITE, 8'hFF, 1'b0, 8'h01);
    issue(ACT_WRITE, 3'd0, END_WRITE, 8'h00, 1'b1, 8'h02);
    // The wrong end for the direction is a bad request.
    issue(ACT_WRITE, 3'd0, END_READ, 8'h55, 1'b1, 8'h03);
    issue(ACT_READ, 3'd0, END_WRITE, 8'hAA, 1'b1, 8'h04);
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b0, 8'h05);
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b1, 8'h06);
    // The last writer leaving wakes a parked reader, who then sees end of file.
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b0, 8'hFF);
    issue(ACT_CLOSE, 3'd0, END_WRITE, 8'h00, 1'b0, 8'h00);
    issue(ACT_READ, 3'd0, END_READ, 8'h00, 1'b1, 8'h07);
    issue(ACT_CLOSE, 3'd0, END_READ, 8'h00, 1'b0, 8'h00);
    // A writer with no reader left gets a broken pipe.
    issue(ACT_OPEN, 3'd0, END_WRITE, 8'h00, 1'b0, 8'h00);
    issue(ACT_WRITE, 3'd0, END_WRITE, 8'h81, 1'b1, 8'h08);
    issue(ACT_CLOSE, 3'd0, END_WRITE, 8'h00, 1'b0, 8'h00);
    // Unknown actions change nothing.
    for (int unsigned a = ACT_READ + 1; a < 8; a++) begin
      issue(3'(a), 3'($urandom), 1'($urandom), rnd8(), 1'($urandom), rnd8());
    end

    fill_session();

    while (sb.requests < REQUEST_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) stream_session();
      else if (pick < 68) handle_flood();
      else if (pick < 78) pool_flood();
      else noise_burst();
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results of %0d requests: ok %0d, eof %0d, would_block %0d,",
             sb.checked, sb.requests, sb.status_seen[STS_OK], sb.status_seen[STS_EOF],
             sb.status_seen[STS_BLOCK]);
    $display("  broken_pipe %0d, bad_request %0d, no_free_pipe %0d, no_free_handle %0d",
             sb.status_seen[STS_BROKEN], sb.status_seen[STS_BAD],
             sb.status_seen[STS_NOPIPE], sb.status_seen[STS_NOHANDLE]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time, even with
  // every gap and every stall at its longest.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
